FILE: rtl/running_mean_variance_stats_unit_defines.svh
// assertion macros for the running mean and variance statistics unit
// expects clk and arst_n in the scope of each use
`ifndef RUNNING_MEAN_VARIANCE_STATS_UNIT_DEFINES_SVH
`define RUNNING_MEAN_VARIANCE_STATS_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RMVS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmvs assertion failed");

// next-cycle implication, disabled in reset
`define RMVS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmvs assertion failed");

`endif

FILE: rtl/rmvs_pkg.sv
// types and constants for the running mean and variance statistics unit
// no dependencies
package rmvs_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int COUNT_BITS     = 16;
	localparam int MEAN_FRAC_BITS = 16;

	localparam int MEAN_BITS     = SAMPLE_BITS + MEAN_FRAC_BITS;
	localparam int DEV_BITS      = MEAN_BITS + 1;
	localparam int MAG_BITS      = MEAN_BITS;
	localparam int PROD_BITS     = 2 * MAG_BITS;
	localparam int TERM_SHIFT    = 2 * MEAN_FRAC_BITS - 8;
	localparam int TERM_BITS     = PROD_BITS - TERM_SHIFT;
	localparam int SUM_BITS      = 56;
	localparam int VAR_BITS      = 40;
	localparam int DIVIDEND_BITS = SUM_BITS;
	localparam int DIVISOR_BITS  = COUNT_BITS;

	localparam int MEAN_DIV_STEPS = MAG_BITS;
	localparam int VAR_DIV_STEPS  = SUM_BITS;
	localparam int STEP_CNT_BITS  = $clog2(VAR_DIV_STEPS);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
	} sample_beat_t;

	typedef struct packed {
		logic [15:0]          sample_count;
		logic signed [31:0]   running_mean;
		logic [VAR_BITS-1:0]  sample_variance;
		logic                 variance_valid;
		logic signed [15:0]   smallest_seen;
		logic signed [15:0]   largest_seen;
		logic                 count_full;
	} result_beat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV_MEAN,
		ST_MEAN,
		ST_MUL,
		ST_ACC,
		ST_VAR_CHK,
		ST_DIV_VAR,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic div_step;
		logic mean_upd;
		logic mul;
		logic acc;
		logic var_load;
		logic capture;
	} ctrl_cmd_t;

	typedef struct packed {
		logic full;
		logic var_ok;
	} dp_status_t;

endpackage

FILE: rtl/rmvs_stream_if.sv
// valid/ready stream channel carrying one payload beat
// payload type set per instance, normally from rmvs_pkg
interface rmvs_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/rmvs_serial_divider.sv
// restoring unsigned divider, one quotient bit per step
// depends on rmvs_pkg for widths
module rmvs_serial_divider (
	input  logic                                 clk,
	input  logic                                 load,
	input  logic                                 step,
	input  logic [rmvs_pkg::DIVIDEND_BITS-1:0]   dividend,
	input  logic [rmvs_pkg::DIVISOR_BITS-1:0]    divisor,
	output logic [rmvs_pkg::DIVIDEND_BITS-1:0]   quotient
);
	import rmvs_pkg::*;

	logic [DIVISOR_BITS-1:0]  rem_q;
	logic [DIVISOR_BITS-1:0]  div_q;
	logic [DIVIDEND_BITS-1:0] quo_q;
	logic [DIVISOR_BITS:0]    trial;
	logic [DIVISOR_BITS:0]    diff;
	logic                     ge;

	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_BITS-1]};
		diff  = trial - {1'b0, div_q};
		ge    = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (step) begin
			rem_q <= ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
			quo_q <= {quo_q[DIVIDEND_BITS-2:0], ge};
		end
	end

	assign quotient = quo_q;
endmodule

FILE: rtl/rmvs_datapath.sv
// statistics datapath: state registers, deviation math, multiplier, result register
// depends on rmvs_pkg, rmvs_serial_divider and the assertion macro header
`include "running_mean_variance_stats_unit_defines.svh"
module rmvs_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  rmvs_pkg::ctrl_cmd_t                cmd,
	input  logic signed [rmvs_pkg::SAMPLE_BITS-1:0] sample,
	output rmvs_pkg::dp_status_t               status,
	output rmvs_pkg::result_beat_t             result
);
	import rmvs_pkg::*;

	logic [COUNT_BITS-1:0]         count_q;
	logic signed [MEAN_BITS-1:0]   mean_q;
	logic [SUM_BITS-1:0]           sum_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic                          full_q;

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          neg_q;
	logic [MAG_BITS-1:0]           mag_old_q;
	logic [MAG_BITS-1:0]           mag_new_q;
	logic signed [MEAN_BITS-1:0]   newmean_q;
	logic [PROD_BITS-1:0]          prod_q;
	result_beat_t                  result_q;

	logic signed [MEAN_BITS-1:0]   scaled;
	logic signed [DEV_BITS-1:0]    d_old;
	logic [DEV_BITS-1:0]           d_old_mag;
	logic signed [DEV_BITS-1:0]    step_val;
	logic signed [DEV_BITS-1:0]    new_mean;
	logic signed [DEV_BITS-1:0]    d_new;
	logic [DEV_BITS-1:0]           d_new_mag;
	logic [SUM_BITS:0]             sum_ext;
	logic [DIVIDEND_BITS-1:0]      div_dividend;
	logic [DIVISOR_BITS-1:0]       div_divisor;
	logic [DIVIDEND_BITS-1:0]      quotient;
	logic [VAR_BITS-1:0]           var_sat;
	logic                          var_ok;

	always_comb begin
		scaled    = {sample_q, {MEAN_FRAC_BITS{1'b0}}};
		d_old     = DEV_BITS'(scaled) - DEV_BITS'(mean_q);
		d_old_mag = d_old[DEV_BITS-1] ? DEV_BITS'(-d_old) : DEV_BITS'(d_old);
		step_val  = neg_q ? -$signed({1'b0, quotient[MAG_BITS-1:0]})
		                  : $signed({1'b0, quotient[MAG_BITS-1:0]});
		new_mean  = DEV_BITS'(mean_q) + step_val;
		d_new     = DEV_BITS'(scaled) - new_mean;
		d_new_mag = d_new[DEV_BITS-1] ? DEV_BITS'(-d_new) : DEV_BITS'(d_new);
		sum_ext   = {1'b0, sum_q} + (SUM_BITS+1)'(prod_q[PROD_BITS-1:TERM_SHIFT]);
		var_ok    = count_q >= COUNT_BITS'(2);
		var_sat   = (|quotient[DIVIDEND_BITS-1:VAR_BITS]) ? '1 : quotient[VAR_BITS-1:0];
		if (cmd.prep) begin
			div_dividend = {d_old_mag[MAG_BITS-1:0], {(DIVIDEND_BITS-MAG_BITS){1'b0}}};
			div_divisor  = count_q + COUNT_BITS'(1);
		end else begin
			div_dividend = sum_q;
			div_divisor  = count_q - COUNT_BITS'(1);
		end
	end

	rmvs_serial_divider u_div (
		.clk      (clk),
		.load     (cmd.prep | cmd.var_load),
		.step     (cmd.div_step),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mean_q  <= '0;
			sum_q   <= '0;
			min_q   <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			max_q   <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			full_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				full_q <= count_q == COUNT_MAX;
			end
			if (cmd.prep) begin
				count_q <= count_q + COUNT_BITS'(1);
			end
			if (cmd.acc) begin
				sum_q  <= sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
				mean_q <= newmean_q;
				if (sample_q < min_q) begin
					min_q <= sample_q;
				end
				if (sample_q > max_q) begin
					max_q <= sample_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample;
		end
		if (cmd.prep) begin
			neg_q     <= d_old[DEV_BITS-1];
			mag_old_q <= d_old_mag[MAG_BITS-1:0];
		end
		if (cmd.mean_upd) begin
			newmean_q <= new_mean[MEAN_BITS-1:0];
			mag_new_q <= d_new_mag[MAG_BITS-1:0];
		end
		if (cmd.mul) begin
			prod_q <= mag_old_q * mag_new_q;
		end
		if (cmd.capture) begin
			result_q.sample_count    <= 16'(count_q);
			result_q.running_mean    <= 32'(mean_q);
			result_q.sample_variance <= var_ok ? var_sat : '0;
			result_q.variance_valid  <= var_ok;
			result_q.smallest_seen   <= 16'(min_q);
			result_q.largest_seen    <= 16'(max_q);
			result_q.count_full      <= full_q;
		end
	end

	assign status.full   = full_q;
	assign status.var_ok = var_ok;
	assign result        = result_q;

	`RMVS_ASSERT_NEXT(a_sum_monotonic, cmd.acc, sum_q >= $past(sum_q))
	`RMVS_ASSERT_NEXT(a_min_le_max, cmd.acc, min_q <= max_q)
	`RMVS_ASSERT_NEXT(a_count_step, cmd.prep, count_q == $past(count_q) + COUNT_BITS'(1))
endmodule

FILE: rtl/rmvs_controller.sv
// sequencer for the statistics unit: handshakes, divider step count, datapath commands
// depends on rmvs_pkg and the assertion macro header
`include "running_mean_variance_stats_unit_defines.svh"
module rmvs_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  rmvs_pkg::dp_status_t status,
	output rmvs_pkg::ctrl_cmd_t  cmd
);
	import rmvs_pkg::*;

	ctrl_state_t              state_q, state_d;
	logic [STEP_CNT_BITS-1:0] step_q, step_d;
	logic                     out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				if (status.full) begin
					state_d = ST_VAR_CHK;
				end else begin
					cmd.prep = 1'b1;
					step_d   = STEP_CNT_BITS'(MEAN_DIV_STEPS - 1);
					state_d  = ST_DIV_MEAN;
				end
			end
			ST_DIV_MEAN: begin
				cmd.div_step = 1'b1;
				step_d       = step_q - STEP_CNT_BITS'(1);
				if (step_q == '0) begin
					state_d = ST_MEAN;
				end
			end
			ST_MEAN: begin
				cmd.mean_upd = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_VAR_CHK;
			end
			ST_VAR_CHK: begin
				if (status.var_ok) begin
					cmd.var_load = 1'b1;
					step_d       = STEP_CNT_BITS'(VAR_DIV_STEPS - 1);
					state_d      = ST_DIV_VAR;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DIV_VAR: begin
				cmd.div_step = 1'b1;
				step_d       = step_q - STEP_CNT_BITS'(1);
				if (step_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.capture = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (cmd.capture) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign out_valid = out_valid_q;

	`RMVS_ASSERT_NOW(a_no_overwrite, cmd.capture, !out_valid_q || out_ready)
	`RMVS_ASSERT_NEXT(a_accept_to_prep, in_valid && in_ready, state_q == ST_PREP)
	`RMVS_ASSERT_NOW(a_var_div_needs_two, state_q == ST_DIV_VAR, status.var_ok)
endmodule

FILE: rtl/running_mean_variance_stats_unit.sv
// top level of the running mean and variance statistics unit
// depends on rmvs_pkg, rmvs_stream_if, rmvs_controller and rmvs_datapath

// Takes one signed 16-bit sample per beat and returns one result beat per sample with
// the saturating count, the Welford running mean (Q16.16), the sample variance
// (Q32.8, squared deviation sum over count minus one, saturated to 40 bits), min, max,
// a variance valid flag (two or more samples) and a count full flag (sample ignored).
// One sample at a time is processed. The time from accept to result is set by the shared
// one-bit-per-cycle restoring divider, 32 steps for the mean update and 56 steps for the
// variance; the mean division is skipped once the count is full and the variance division
// when fewer than two samples are counted. The output register lets the next sample be
// accepted while a result waits to be taken.
module running_mean_variance_stats_unit (
	input  logic          clk,
	input  logic          arst_n,
	rmvs_stream_if.sink   samples,
	rmvs_stream_if.source results
);
	import rmvs_pkg::*;

	ctrl_cmd_t    cmd;
	dp_status_t   status;
	sample_beat_t in_beat;
	result_beat_t out_beat;

	assign in_beat = samples.data;

	rmvs_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	rmvs_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sample (in_beat.sample),
		.status (status),
		.result (out_beat)
	);

	assign results.data = out_beat;
endmodule
